[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// hold prop on every edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// expr must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

[hdl/hnv_pkg.sv]
// ----------------------------------------------------------------------------
// hnv_pkg
// Types and constants of the host name validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hnv_pkg;

  localparam int unsigned MAX_LABEL_LEN_DEF = 63;
  localparam int unsigned MAX_HOST_LEN_DEF  = 253;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CASE_OFS  = 8'h20;

  localparam logic [47:0] LOCAL_WORD = 48'h2E6C6F63616C;

  localparam logic [7:0] OCT_MAX      = 8'd255;
  localparam logic [7:0] NET_TEN      = 8'd10;
  localparam logic [7:0] NET_192      = 8'd192;
  localparam logic [7:0] NET_168      = 8'd168;
  localparam logic [7:0] NET_172      = 8'd172;
  localparam logic [7:0] NET_172_LO   = 8'd16;
  localparam logic [7:0] NET_172_HI   = 8'd31;
  localparam logic [7:0] NET_LOOPBACK = 8'd127;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       char_present;
    logic       last_char;
    logic       secure_scheme;
  } hnv_item_t;

  typedef struct packed {
    logic host_accepted;
    logic is_dotted_quad;
    logic is_private_addr;
    logic is_valid_hostname;
    logic is_local_suffix;
  } hnv_verdict_t;

endpackage

[hdl/hnv_in_reg.sv]
// ----------------------------------------------------------------------------
// hnv_in_reg
// Input register: captures one transaction and holds it until it advances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hnv_in_reg
  import hnv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  hnv_item_t in_item,
  input  logic      advance,
  output logic      item_vld,
  output hnv_item_t item
);

  logic      vld_r;
  logic      vld_nxt;
  hnv_item_t item_r;

  assign in_tready = !vld_r || advance;
  assign vld_nxt   = in_tready ? in_tvalid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

[hdl/hnv_scan.sv]
// ----------------------------------------------------------------------------
// hnv_scan
// Per-byte scan state and verdict logic for dotted quad, hostname and suffix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hnv_scan
  import hnv_pkg::*;
#(
  parameter int unsigned MAX_LABEL_LEN = MAX_LABEL_LEN_DEF,
  parameter int unsigned MAX_HOST_LEN  = MAX_HOST_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  hnv_item_t    item,
  output hnv_verdict_t verdict
);

  typedef struct packed {
    logic [7:0]  total_len;
    logic [6:0]  label_len;
    logic        lbl_hyph;
    logic        prev_hyph;
    logic        host_fail;
    logic        quad_fail;
    logic [2:0]  octet_cnt;
    logic [2:0]  digit_cnt;
    logic [9:0]  octet_val;
    logic [7:0]  oct0;
    logic [7:0]  oct1;
    logic [47:0] sfx;
  } hnv_state_t;

  function automatic hnv_state_t close_octet(hnv_state_t s);
    hnv_state_t r;
    r = s;
    if (s.octet_cnt >= 3'd4 || s.digit_cnt == 3'd0 || s.digit_cnt > 3'd3 ||
        s.octet_val > {2'b00, OCT_MAX}) begin
      r.quad_fail = 1'b1;
    end else begin
      if (s.octet_cnt == 3'd0) begin
        r.oct0 = s.octet_val[7:0];
      end else if (s.octet_cnt == 3'd1) begin
        r.oct1 = s.octet_val[7:0];
      end
      r.octet_cnt = s.octet_cnt + 3'd1;
    end
    r.digit_cnt = 3'd0;
    r.octet_val = 10'd0;
    return r;
  endfunction

  function automatic hnv_state_t close_label(hnv_state_t s);
    hnv_state_t r;
    r = s;
    if (s.label_len == 7'd0 || s.lbl_hyph || s.prev_hyph) begin
      r.host_fail = 1'b1;
    end
    r.label_len = 7'd0;
    r.lbl_hyph  = 1'b0;
    r.prev_hyph = 1'b0;
    return r;
  endfunction

  hnv_state_t  st_r;
  hnv_state_t  st_nxt;
  hnv_state_t  a_st;
  hnv_state_t  b_st;
  logic [7:0]  c;
  logic [7:0]  lowc;
  logic        is_hyph;
  logic        is_digit;
  logic        is_letter;
  logic [13:0] prod;
  logic        quad;
  logic        host;
  logic        lcl;
  logic        priv;

  assign c = item.char_byte;

  always_comb begin
    lowc      = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
    is_hyph   = (c == CH_HYPHEN);
    is_digit  = (c >= CH_ZERO && c <= CH_NINE);
    is_letter = (lowc >= CH_LO_A && lowc <= CH_LO_Z);
    prod      = 14'(st_r.octet_val) * 14'd10 + 14'(c[3:0]);
    a_st      = st_r;
    if (item.char_present) begin
      if (st_r.total_len >= 8'(MAX_HOST_LEN)) begin
        a_st.host_fail = 1'b1;
      end
      if (st_r.total_len != 8'hFF) begin
        a_st.total_len = st_r.total_len + 8'd1;
      end
      a_st.sfx = {st_r.sfx[39:0], lowc};
      if (c == CH_DOT) begin
        a_st = close_label(close_octet(a_st));
      end else begin
        if (is_digit) begin
          if (st_r.digit_cnt != 3'd7) begin
            a_st.digit_cnt = st_r.digit_cnt + 3'd1;
          end
          a_st.octet_val = (prod > 14'd1023) ? 10'd1023 : prod[9:0];
        end else begin
          a_st.quad_fail = 1'b1;
        end
        if (!(is_letter || is_digit || is_hyph)) begin
          a_st.host_fail = 1'b1;
        end
        if (st_r.label_len == 7'd0) begin
          a_st.lbl_hyph = is_hyph;
        end
        if (st_r.label_len >= 7'(MAX_LABEL_LEN)) begin
          a_st.host_fail = 1'b1;
        end
        if (st_r.label_len != 7'h7F) begin
          a_st.label_len = st_r.label_len + 7'd1;
        end
        a_st.prev_hyph = is_hyph;
      end
    end
    b_st = close_label(close_octet(a_st));
  end

  always_comb begin
    if (a_st.total_len == 8'd0) begin
      quad = 1'b0;
      host = 1'b0;
      lcl  = 1'b0;
    end else begin
      quad = !b_st.quad_fail && (b_st.octet_cnt == 3'd4);
      host = !b_st.host_fail;
      lcl  = (a_st.total_len > 8'd6) && (a_st.sfx == LOCAL_WORD);
    end
    priv = quad && ((b_st.oct0 == NET_TEN) ||
                    (b_st.oct0 == NET_192 && b_st.oct1 == NET_168) ||
                    (b_st.oct0 == NET_172 && b_st.oct1 >= NET_172_LO &&
                     b_st.oct1 <= NET_172_HI) ||
                    (b_st.oct0 == NET_LOOPBACK));
    verdict.host_accepted     = item.secure_scheme ? (quad || host) : (priv || lcl);
    verdict.is_dotted_quad    = quad;
    verdict.is_private_addr   = priv;
    verdict.is_valid_hostname = host;
    verdict.is_local_suffix   = lcl;
  end

  always_comb begin
    st_nxt = st_r;
    if (step) begin
      st_nxt = item.last_char ? '0 : a_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

[hdl/hnv_out_reg.sv]
// ----------------------------------------------------------------------------
// hnv_out_reg
// Result register: holds one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hnv_out_reg
  import hnv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  hnv_verdict_t verdict,
  output logic         out_free,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata
);

  logic         vld_r;
  logic         vld_nxt;
  hnv_verdict_t res_r;

  assign out_free = !vld_r || out_tready;
  assign vld_nxt  = load ? 1'b1 : (vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= verdict;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {3'b000, res_r.is_local_suffix, res_r.is_valid_hostname,
                       res_r.is_private_addr, res_r.is_dotted_quad,
                       res_r.host_accepted};

endmodule

[hdl/host_name_validator_top.sv]
// ----------------------------------------------------------------------------
// host_name_validator_top
// Streams a host name byte by byte and emits one verdict per string.
//
//   channel  dir  tdata                                 tuser          tlast
//   in_      in   [7:0] char_byte, [8] char_present     secure_scheme  last_char
//   out_     out  [0] accepted [1] quad [2] private     -              -
//                 [3] hostname [4] local suffix
//
// One byte per cycle while the result side keeps up; a verdict reaches out_ once
// the tlast transaction has passed the input register and then the result register.
// Scan state updates as a byte leaves the input register; tlast clears it.
// in_tready drops only while a tlast byte waits on a full, stalled result.
// Reset is synchronous, active low, and clears all scan state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module host_name_validator_top
  import hnv_pkg::*;
#(
  parameter int unsigned MAX_LABEL_LEN = MAX_LABEL_LEN_DEF,
  parameter int unsigned MAX_HOST_LEN  = MAX_HOST_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] char_byte, [8] char_present, rest zero
  input  logic        in_tuser,   // [0] secure_scheme
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] host_accepted, [1] is_dotted_quad,
                                  // [2] is_private_addr, [3] is_valid_hostname,
                                  // [4] is_local_suffix, rest zero
);

  hnv_item_t    in_item;
  hnv_item_t    item;
  hnv_verdict_t verdict;
  logic         item_vld;
  logic         advance;
  logic         out_free;
  logic         load;

  assign in_item.char_byte     = in_tdata[7:0];
  assign in_item.char_present  = in_tdata[8];
  assign in_item.last_char     = in_tlast;
  assign in_item.secure_scheme = in_tuser;

  assign advance = item_vld && (!item.last_char || out_free);
  assign load    = advance && item.last_char;

  hnv_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .advance   (advance),
    .item_vld  (item_vld),
    .item      (item)
  );

  hnv_scan #(
    .MAX_LABEL_LEN (MAX_LABEL_LEN),
    .MAX_HOST_LEN  (MAX_HOST_LEN)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .item    (item),
    .verdict (verdict)
  );

  hnv_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .verdict    (verdict),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `ASSERT_PROP(a_stall_cause, clk, rst_n, !in_tready |-> (item_vld && item.last_char && out_tvalid && !out_tready), "input stalled without a blocked result")
  `ASSERT_PROP(a_load_shows, clk, rst_n, load |=> out_tvalid, "loaded verdict not presented")
  `ASSERT_NEVER(a_priv_quad, clk, rst_n, out_tvalid && out_tdata[2] && !out_tdata[1], "private flag without dotted quad")
  `ASSERT_NEVER(a_accept_basis, clk, rst_n, out_tvalid && out_tdata[0] && (out_tdata[4:1] == 4'b0000), "accepted without any passing check")

endmodule

[tb/host_name_validator_checker.sv]
// ----------------------------------------------------------------------------
// host_name_validator_checker
// Watches both stream channels of the host name validator. It tracks every
// accepted input transaction with its own scan of the host string. When a
// transaction carries tlast, it queues the verdict it works out. Each verdict
// the block delivers is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module host_name_validator_checker
  import hnv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] char_byte, [8] char_present, rest zero
  input  logic        in_tuser,   // [0] secure_scheme
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [0] host_accepted, [1] is_dotted_quad,
                                  // [2] is_private_addr, [3] is_valid_hostname,
                                  // [4] is_local_suffix, rest zero
  output int unsigned fail_count,
  output int unsigned pending_count,
  output int unsigned verdict_count,
  output int unsigned accepted_count
);

  localparam int unsigned PRINT_LIMIT = 100;

  hnv_verdict_t expected_verdicts[$];

  logic [7:0]  total_len;
  logic [6:0]  label_len;
  logic        lead_hyphen;
  logic        prev_hyphen;
  logic        host_bad;
  logic        quad_bad;
  logic [2:0]  octet_cnt;
  logic [2:0]  digit_cnt;
  logic [9:0]  octet_val;
  logic [7:0]  first_oct;
  logic [7:0]  second_oct;
  logic [47:0] tail6;

  task automatic clear_scan();
    total_len   = '0;
    label_len   = '0;
    lead_hyphen = 1'b0;
    prev_hyphen = 1'b0;
    host_bad    = 1'b0;
    quad_bad    = 1'b0;
    octet_cnt   = '0;
    digit_cnt   = '0;
    octet_val   = '0;
    first_oct   = '0;
    second_oct  = '0;
    tail6       = '0;
  endtask

  task automatic close_octet();
    if (octet_cnt >= 4 || digit_cnt == 0 || digit_cnt > 3 || octet_val > OCT_MAX) begin
      quad_bad = 1'b1;
    end else begin
      if (octet_cnt == 0)
        first_oct = octet_val[7:0];
      else if (octet_cnt == 1)
        second_oct = octet_val[7:0];
      octet_cnt++;
    end
    digit_cnt = '0;
    octet_val = '0;
  endtask

  task automatic close_label();
    if (label_len == 0 || lead_hyphen || prev_hyphen)
      host_bad = 1'b1;
    label_len   = '0;
    lead_hyphen = 1'b0;
    prev_hyphen = 1'b0;
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_LIMIT)
      $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic exp_bit, input logic got_bit);
    if (got_bit !== exp_bit)
      report_mismatch($sformatf("verdict %0d %s: expected %b, got %b",
                                verdict_count, name, exp_bit, got_bit));
  endtask

  task automatic scan_host_item(input logic [7:0] c, input logic present,
                                input logic last, input logic secure);
    logic [7:0]   folded;
    logic         is_hyphen;
    logic         is_digit;
    logic         is_letter;
    int           acc;
    hnv_verdict_t v;
    if (present) begin
      folded    = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
      is_hyphen = (c == CH_HYPHEN);
      is_digit  = (c >= CH_ZERO && c <= CH_NINE);
      is_letter = (folded >= CH_LO_A && folded <= CH_LO_Z);
      if (total_len >= MAX_HOST_LEN_DEF)
        host_bad = 1'b1;
      if (total_len != 8'hFF)
        total_len++;
      tail6 = {tail6[39:0], folded};
      if (c == CH_DOT) begin
        close_octet();
        close_label();
      end else begin
        if (is_digit) begin
          if (digit_cnt != 3'd7)
            digit_cnt++;
          acc = octet_val * 10 + c - CH_ZERO;
          octet_val = (acc > 1023) ? 10'd1023 : 10'(acc);
        end else begin
          quad_bad = 1'b1;
        end
        if (!(is_letter || is_digit || is_hyphen))
          host_bad = 1'b1;
        if (label_len == 0)
          lead_hyphen = is_hyphen;
        if (label_len >= MAX_LABEL_LEN_DEF)
          host_bad = 1'b1;
        if (label_len != 7'h7F)
          label_len++;
        prev_hyphen = is_hyphen;
      end
    end
    if (!last)
      return;
    v = '0;
    if (total_len != 0) begin
      close_octet();
      close_label();
      v.is_dotted_quad    = !quad_bad && octet_cnt == 4;
      v.is_valid_hostname = !host_bad;
      v.is_local_suffix   = total_len > 6 && tail6 == LOCAL_WORD;
    end
    v.is_private_addr = v.is_dotted_quad &&
                        (first_oct == NET_TEN ||
                         (first_oct == NET_192 && second_oct == NET_168) ||
                         (first_oct == NET_172 && second_oct >= NET_172_LO &&
                          second_oct <= NET_172_HI) ||
                         first_oct == NET_LOOPBACK);
    v.host_accepted = secure ? (v.is_dotted_quad || v.is_valid_hostname)
                             : (v.is_private_addr || v.is_local_suffix);
    expected_verdicts.push_back(v);
    clear_scan();
  endtask

  task automatic check_verdict();
    hnv_verdict_t exp_v;
    if (expected_verdicts.size() == 0) begin
      report_mismatch($sformatf("verdict 0x%h with none outstanding", out_tdata));
      return;
    end
    exp_v = expected_verdicts.pop_front();
    verdict_count++;
    if (out_tdata[0] === 1'b1)
      accepted_count++;
    check_field("host_accepted", exp_v.host_accepted, out_tdata[0]);
    check_field("is_dotted_quad", exp_v.is_dotted_quad, out_tdata[1]);
    check_field("is_private_addr", exp_v.is_private_addr, out_tdata[2]);
    check_field("is_valid_hostname", exp_v.is_valid_hostname, out_tdata[3]);
    check_field("is_local_suffix", exp_v.is_local_suffix, out_tdata[4]);
    check_field("padding", 1'b0, |out_tdata[7:5]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      expected_verdicts.delete();
      fail_count     = 0;
      pending_count  = 0;
      verdict_count  = 0;
      accepted_count = 0;
    end else begin
      if (out_tvalid && out_tready)
        check_verdict();
      if (in_tvalid && in_tready)
        scan_host_item(in_tdata[7:0], in_tdata[8], in_tlast, in_tuser);
      pending_count = expected_verdicts.size();
    end
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the host name validator. A directed set of host
// strings comes first. Random dotted quads, host names, .local names, noise
// and damaged strings follow, with random gaps on the input and output sides.
// Twice the receiver holds off long enough to back up the input. The checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import hnv_pkg::*;

  localparam int unsigned TOTAL_ITEMS  = 1550;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned verdict_count;
  int unsigned accepted_count;

  int unsigned items_sent   = 0;
  int unsigned strings_sent = 0;
  int unsigned input_stalls = 0;
  int unsigned hold_count   = 0;
  bit          quiet        = 1'b0;
  bit          rx_hold      = 1'b0;
  byte unsigned host_bytes[$];

  host_name_validator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  host_name_validator_checker verdict_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .verdict_count  (verdict_count),
    .accepted_count (accepted_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned gap_len();
    int unsigned r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic byte unsigned label_char(input bit hyphen_ok);
    int unsigned r = $urandom_range(0, 9);
    if (r < 4) return 8'(CH_LO_A + $urandom_range(0, 25));
    if (r < 6) return 8'(CH_UP_A + $urandom_range(0, 25));
    if (r < 8 || !hyphen_ok) return 8'(CH_ZERO + $urandom_range(0, 9));
    return CH_HYPHEN;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) host_bytes.push_back(s[i]);
  endtask

  task automatic fill_run(input byte unsigned ch, input int unsigned n);
    repeat (n) host_bytes.push_back(ch);
  endtask

  task automatic send_item(input logic [7:0] c, input logic present,
                           input logic last, input logic secure);
    int unsigned g;
    g = quiet ? 0 : gap_len();
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, present, c};
    in_tuser  <= secure;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_host(input bit secure, input bit byteless_end,
                           input int unsigned skip_pct);
    int unsigned n;
    bit          last;
    n = host_bytes.size();
    quiet = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < skip_pct)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
      last = (i + 1 == n) && !byteless_end;
      send_item(host_bytes[i], 1'b1, last, last ? secure : 1'($urandom_range(0, 1)));
    end
    if (n == 0 || byteless_end)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, secure);
    strings_sent++;
  endtask

  task automatic send_text(input string s, input bit secure, input bit byteless_end,
                           input int unsigned skip_pct);
    host_bytes.delete();
    push_text(s);
    send_host(secure, byteless_end, skip_pct);
  endtask

  task automatic gen_quad();
    int unsigned n_oct, r, a, b, v, w;
    r = $urandom_range(0, 9);
    a = $urandom_range(0, 255);
    b = $urandom_range(0, 255);
    case (r)
      0: a = NET_TEN;
      1: begin a = NET_192; b = NET_168; end
      2: begin a = NET_172; b = $urandom_range(14, 33); end
      3: a = NET_LOOPBACK;
      4: begin a = NET_192; b = $urandom_range(166, 170); end
      5: a = $urandom_range(8, 12);
      6: a = $urandom_range(125, 129);
      default: ;
    endcase
    n_oct = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 4;
    for (int i = 0; i < n_oct; i++) begin
      if (i != 0)
        host_bytes.push_back(CH_DOT);
      v = (i == 0) ? a : (i == 1) ? b : $urandom_range(0, 255);
      w = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
      if ($urandom_range(0, 4) == 0)
        w = $urandom_range(w, 3);
      r = $urandom_range(0, 29);
      if (r == 0) begin
        v = $urandom_range(256, 999);
        w = 3;
      end else if (r == 1) begin
        w = 0;
      end else if (r == 2) begin
        v = $urandom_range(0, 99999999);
        w = $urandom_range(4, 8);
      end
      // emit w digits, most significant first
      for (int k = w; k > 0; k--) begin
        a = v;
        for (int m = 1; m < k; m++) a = a / 10;
        host_bytes.push_back(8'(CH_ZERO + a % 10));
      end
    end
    if ($urandom_range(0, 29) == 0)
      host_bytes.push_back(CH_DOT);
  endtask

  task automatic gen_hostname(input int unsigned max_len);
    int unsigned n_lab, len, r;
    n_lab = $urandom_range(1, 4);
    for (int i = 0; i < n_lab; i++) begin
      if (i != 0)
        host_bytes.push_back(CH_DOT);
      r = $urandom_range(0, 39);
      len = (r == 0) ? 0 : (r == 1) ? MAX_LABEL_LEN_DEF :
            (r == 2) ? MAX_LABEL_LEN_DEF + 1 : $urandom_range(1, max_len);
      for (int j = 0; j < len; j++)
        host_bytes.push_back((r == 3 && (j == 0 || j + 1 == len)) ? CH_HYPHEN :
                             label_char(j != 0 && j + 1 != len));
      if (r == 4 && len != 0)
        host_bytes[host_bytes.size() - 1] = 8'($urandom_range(0, 255));
    end
  endtask

  // receiver: random ready runs and stalls, forced low during a hold-off
  initial begin
    int unsigned ready_run, idle_run;
    ready_run = 0;
    idle_run  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_tready <= 1'b0;
      end else if (ready_run != 0) begin
        out_tready <= 1'b1;
        ready_run--;
      end else if (idle_run != 0) begin
        out_tready <= 1'b0;
        idle_run--;
      end else begin
        out_tready <= 1'b1;
        ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) :
                                                  $urandom_range(0, 8);
        idle_run  = gap_len();
      end
    end
  end

  // hold off the receiver while the sender keeps offering
  initial begin
    for (int k = 0; k < 2; k++) begin
      wait (strings_sent >= 10 + 15 * k);
      @(negedge clk);
      rx_hold = 1'b1;
      hold_count++;
      repeat (HOLD_CYCLES) @(negedge clk);
      rx_hold = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && !in_tready)
      input_stalls++;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned  r, n, pos, target, items_goal;
    string        suffix;
    byte unsigned ch;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    host_bytes.delete();
    send_host(1'b1, 1'b0, 0);
    send_host(1'b0, 1'b0, 0);
    send_text("10.0.0.1", 1'b0, 1'b0, 0);
    send_text("255.255.255.255", 1'b1, 1'b0, 0);
    send_text("256.1.1.1", 1'b1, 1'b0, 0);
    send_text("001.02.3.004", 1'b0, 1'b0, 0);
    send_text("192.168.1.1", 1'b0, 1'b1, 0);
    send_text("172.16.0.1", 1'b0, 1'b0, 0);
    send_text("172.31.255.255", 1'b0, 1'b0, 0);
    send_text("172.32.0.1", 1'b0, 1'b0, 0);
    send_text("127.0.0.1", 1'b0, 1'b0, 0);
    send_text("12345678.1.1.1", 1'b1, 1'b0, 0);
    send_text("1.2.3", 1'b1, 1'b0, 0);
    send_text("1.2.3.4.5", 1'b1, 1'b0, 0);
    send_text("1..2.3", 1'b1, 1'b0, 0);
    send_text("Host-Name.Example", 1'b1, 1'b0, 100);
    send_text("-bad.com", 1'b1, 1'b0, 0);
    send_text("bad-.com", 1'b1, 1'b0, 0);
    send_text("printer.LOCAL", 1'b0, 1'b0, 0);
    send_text(".local", 1'b0, 1'b0, 0);
    send_text("x.LoCaL", 1'b1, 1'b0, 0);
    // longest legal label, then one byte over
    for (int k = 0; k < 2; k++) begin
      host_bytes.delete();
      fill_run("a", MAX_LABEL_LEN_DEF + k);
      push_text(".com");
      send_host(1'b1, 1'b0, 0);
    end
    // longest legal host, one byte over, and far past saturation
    for (int k = 0; k < 2; k++) begin
      host_bytes.delete();
      repeat (3) begin
        fill_run("z", MAX_LABEL_LEN_DEF);
        host_bytes.push_back(CH_DOT);
      end
      fill_run("9", MAX_HOST_LEN_DEF - 3 * (MAX_LABEL_LEN_DEF + 1) + k);
      send_host(1'b1, 1'b0, 0);
    end
    host_bytes.delete();
    fill_run("b", 300);
    send_host(1'b1, 1'b0, 0);
    host_bytes.delete();
    host_bytes.push_back("a");
    host_bytes.push_back(8'h00);
    host_bytes.push_back("b");
    send_host(1'b1, 1'b0, 0);
    host_bytes.delete();
    host_bytes.push_back(8'hFF);
    send_host(1'b0, 1'b0, 0);

    items_goal = TOTAL_ITEMS;
    while (items_sent < items_goal) begin
      r = $urandom_range(0, 99);
      host_bytes.delete();
      if (r < 28) begin
        gen_quad();
      end else if (r < 56) begin
        gen_hostname(12);
      end else if (r < 70) begin
        gen_hostname(8);
        suffix = ".local";
        for (int k = 0; k < suffix.len(); k++) begin
          ch = suffix[k];
          if (ch != CH_DOT && $urandom_range(0, 2) == 0)
            ch = ch - CASE_OFS;
          host_bytes.push_back(ch);
        end
      end else if (r < 80) begin
        n = $urandom_range(1, 12);
        repeat (n) host_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 95) begin
        if (r < 88)
          gen_quad();
        else
          gen_hostname(12);
        // damage one spot
        if (host_bytes.size() != 0) begin
          pos = $urandom_range(0, host_bytes.size() - 1);
          n = $urandom_range(0, 3);
          if (n == 0)
            host_bytes[pos] = 8'($urandom_range(0, 255));
          else if (n == 1)
            host_bytes.insert(pos, 8'($urandom_range(0, 255)));
          else if (n == 2)
            host_bytes.delete(pos);
          else
            host_bytes.insert(pos, CH_DOT);
        end
      end else if (r < 97) begin
        target = $urandom_range(240, 300);
        for (int p = 0; p < target; p++)
          host_bytes.push_back((p % 64 == 63) ? CH_DOT : label_char(1'b1));
      end
      send_host(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0, 4);
    end
    in_tvalid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d verdicts over %0d strings and %0d input transactions, %0d accepted",
             verdict_count, strings_sent, items_sent, accepted_count);
    $display("receiver held off %0d times for %0d cycles, input stalled %0d cycles",
             hold_count, HOLD_CYCLES, input_stalls);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
